/* rtl/orls_pkg.sv */
// Package for the overwriting ring log store: sizes, codes, item and control types.
package orls_pkg;

  // Store depth and derived widths
  localparam int SLOTS     = 1024;
  localparam int PTR_W     = $clog2(SLOTS);
  localparam int CAP_W     = PTR_W + 1;
  localparam int PORT_W    = 8;
  localparam int PERIOD_W  = 16;
  localparam int DATA_W    = 32;
  localparam int LOOK_W    = 16;
  localparam int REC_W     = PORT_W + PERIOD_W + DATA_W;
  localparam int DIV_CNT_W = $clog2(CAP_W + 1);

  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(SLOTS);

  // Command codes
  typedef enum logic [1:0] {
    CMD_SAVE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_LOOK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TDIV,
    ST_HCHK,
    ST_HDIV,
    ST_RESULT
  } state_t;

  // One input item
  typedef struct packed {
    logic [1:0]          cmd;
    logic [PORT_W-1:0]   rec_port;
    logic [PERIOD_W-1:0] rec_period;
    logic [DATA_W-1:0]   rec_data;
    logic [PTR_W-1:0]    slot;
    logic [LOOK_W-1:0]   lookback;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [PORT_W-1:0]   out_port;
    logic [PERIOD_W-1:0] out_period;
    logic [DATA_W-1:0]   out_data;
    logic [PTR_W-1:0]    found_slot;
    logic [PTR_W-1:0]    head_now;
    logic [PTR_W-1:0]    tail_now;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted item
    logic mem_we;       // write record at tail
    logic mem_re;       // read record at slot
    logic look_load;    // register the lookback answer
    logic ptr_clear;    // zero both pointers
    logic tail_adv;     // update tail with its advanced value
    logic head_adv;     // update head with its advanced value
    logic adv_from_div; // advanced value comes from the remainder unit
    logic div_start;    // load the remainder unit
    logic div_sel_head; // remainder unit source: head (1) or tail (0)
    logic div_step;     // one remainder step
    logic out_load;     // load the output register
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic tail_slow;    // tail + 1 exceeds capacity
    logic head_slow;    // head + 1 exceeds capacity
    logic ptr_meet;     // tail equals head
    logic div_done;
    logic out_free;     // output register can take a result
  } status_t;

endpackage

/* rtl/orls_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface orls_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [orls_pkg::PORT_W-1:0]   rec_port;
  logic [orls_pkg::PERIOD_W-1:0] rec_period;
  logic [orls_pkg::DATA_W-1:0]   rec_data;
  logic [orls_pkg::PTR_W-1:0]    slot;
  logic [orls_pkg::LOOK_W-1:0]   lookback;

  modport source (output valid, cmd, rec_port, rec_period, rec_data, slot, lookback,
                  input ready);
  modport sink   (input valid, cmd, rec_port, rec_period, rec_data, slot, lookback,
                  output ready);
endinterface

interface orls_out_if;
  logic                          valid;
  logic                          ready;
  logic [orls_pkg::PORT_W-1:0]   out_port;
  logic [orls_pkg::PERIOD_W-1:0] out_period;
  logic [orls_pkg::DATA_W-1:0]   out_data;
  logic [orls_pkg::PTR_W-1:0]    found_slot;
  logic [orls_pkg::PTR_W-1:0]    head_now;
  logic [orls_pkg::PTR_W-1:0]    tail_now;

  modport source (output valid, out_port, out_period, out_data, found_slot, head_now,
                  tail_now, input ready);
  modport sink   (input valid, out_port, out_period, out_data, found_slot, head_now,
                  tail_now, output ready);
endinterface

/* rtl/orls_datapath.sv */
// Datapath: item registers, pointers, capacity, record memory, remainder unit, output register.
module orls_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  orls_pkg::in_item_t          in_item,
  input  logic                        cfg_we,
  input  logic [orls_pkg::CAP_W-1:0]  cfg_wdata,
  input  orls_pkg::ctrl_t             ctl,
  output orls_pkg::status_t           sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output orls_pkg::out_item_t         out_item
);

  localparam int PTR_W   = orls_pkg::PTR_W;
  localparam int CAP_W   = orls_pkg::CAP_W;
  localparam int LOOK_W  = orls_pkg::LOOK_W;
  localparam int REC_W   = orls_pkg::REC_W;
  localparam int DATA_W  = orls_pkg::DATA_W;
  localparam int PER_W   = orls_pkg::PERIOD_W;
  localparam int PORT_W  = orls_pkg::PORT_W;
  localparam int CNT_W   = orls_pkg::DIV_CNT_W;

  // Latched item
  orls_pkg::cmd_t        cmd_r;
  logic [REC_W-1:0]      rec_r;
  logic [PTR_W-1:0]      slot_r;
  logic [LOOK_W-1:0]     look_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= orls_pkg::cmd_t'(in_item.cmd);
      rec_r  <= {in_item.rec_port, in_item.rec_period, in_item.rec_data};
      slot_r <= in_item.slot;
      look_r <= in_item.lookback;
    end
  end

  // Capacity register, saturated on write
  logic [CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= orls_pkg::CAP_MAX;
    end else if (cfg_we) begin
      if (cfg_wdata < orls_pkg::CAP_MIN) begin
        cap_r <= orls_pkg::CAP_MIN;
      end else if (cfg_wdata > orls_pkg::CAP_MAX) begin
        cap_r <= orls_pkg::CAP_MAX;
      end else begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Pointer increments and their fast modulo
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CAP_W-1:0] tail_inc, head_inc;
  logic [PTR_W-1:0] tail_fast, head_fast;

  assign tail_inc  = {1'b0, tail_r} + CAP_W'(1);
  assign head_inc  = {1'b0, head_r} + CAP_W'(1);
  assign tail_fast = (tail_inc == cap_r) ? '0 : tail_inc[PTR_W-1:0];
  assign head_fast = (head_inc == cap_r) ? '0 : head_inc[PTR_W-1:0];

  // Remainder unit: restoring, one quotient bit a cycle
  logic [CAP_W-1:0] div_rem_r, div_dvd_r;
  logic [CNT_W-1:0] div_cnt_r;
  logic [CAP_W:0]   div_trial;

  assign div_trial = {div_rem_r, div_dvd_r[CAP_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (ctl.div_start) begin
      div_cnt_r <= CNT_W'(CAP_W);
    end else if (ctl.div_step && div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      div_rem_r <= '0;
      div_dvd_r <= ctl.div_sel_head ? head_inc : tail_inc;
    end else if (ctl.div_step && div_cnt_r != '0) begin
      div_dvd_r <= {div_dvd_r[CAP_W-2:0], 1'b0};
      if (div_trial >= {1'b0, cap_r}) begin
        div_rem_r <= CAP_W'(div_trial - {1'b0, cap_r});
      end else begin
        div_rem_r <= div_trial[CAP_W-1:0];
      end
    end
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (ctl.ptr_clear) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (ctl.tail_adv) begin
        tail_r <= ctl.adv_from_div ? div_rem_r[PTR_W-1:0] : tail_fast;
      end
      if (ctl.head_adv) begin
        head_r <= ctl.adv_from_div ? div_rem_r[PTR_W-1:0] : head_fast;
      end
    end
  end

  // Record memory, registered read
  logic [REC_W-1:0] mem [orls_pkg::SLOTS];
  logic [REC_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      mem[tail_r] <= rec_r;
    end
    if (ctl.mem_re) begin
      rdata_r <= mem[slot_r];
    end
  end

  // Lookback answer
  logic [LOOK_W-1:0] cap_w, tail_w;
  logic [PTR_W-1:0]  found_nxt, found_r;

  assign cap_w  = LOOK_W'(cap_r);
  assign tail_w = LOOK_W'(tail_r);

  always_comb begin
    if (look_r == '0 || look_r > cap_w) begin
      found_nxt = head_r;
    end else if (head_r > tail_r) begin
      if (look_r > tail_w) begin
        found_nxt = PTR_W'(cap_w + tail_w - look_r);
      end else begin
        found_nxt = PTR_W'(tail_w - look_r);
      end
    end else if (look_r > tail_w) begin
      found_nxt = head_r;
    end else begin
      found_nxt = PTR_W'(tail_w - look_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.look_load) begin
      found_r <= found_nxt;
    end
  end

  // Output register
  logic      out_valid_r;
  orls_pkg::out_item_t out_item_r, out_item_nxt;

  always_comb begin
    out_item_nxt            = '0;
    out_item_nxt.head_now   = head_r;
    out_item_nxt.tail_now   = tail_r;
    if (cmd_r == orls_pkg::CMD_READ) begin
      out_item_nxt.out_port   = rdata_r[REC_W-1 -: PORT_W];
      out_item_nxt.out_period = rdata_r[DATA_W +: PER_W];
      out_item_nxt.out_data   = rdata_r[DATA_W-1:0];
    end
    if (cmd_r == orls_pkg::CMD_LOOK) begin
      out_item_nxt.found_slot = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Status back to the controller
  assign sts.cmd       = cmd_r;
  assign sts.tail_slow = tail_inc > cap_r;
  assign sts.head_slow = head_inc > cap_r;
  assign sts.ptr_meet  = tail_r == head_r;
  assign sts.div_done  = div_cnt_r == '0;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

/* rtl/orls_ctrl.sv */
// Controller: sequences save, read, lookback and clear through the datapath.
module orls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  orls_pkg::status_t sts,
  output orls_pkg::ctrl_t   ctl
);

  orls_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= orls_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      orls_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = orls_pkg::ST_EXEC;
      end
      orls_pkg::ST_EXEC: begin
        unique case (sts.cmd)
          orls_pkg::CMD_SAVE:
            state_nxt = sts.tail_slow ? orls_pkg::ST_TDIV : orls_pkg::ST_HCHK;
          default: state_nxt = orls_pkg::ST_RESULT;
        endcase
      end
      orls_pkg::ST_TDIV: begin
        if (sts.div_done) state_nxt = orls_pkg::ST_HCHK;
      end
      orls_pkg::ST_HCHK: begin
        if (sts.ptr_meet && sts.head_slow) begin
          state_nxt = orls_pkg::ST_HDIV;
        end else begin
          state_nxt = orls_pkg::ST_RESULT;
        end
      end
      orls_pkg::ST_HDIV: begin
        if (sts.div_done) state_nxt = orls_pkg::ST_RESULT;
      end
      orls_pkg::ST_RESULT: begin
        if (sts.out_free) state_nxt = orls_pkg::ST_IDLE;
      end
      default: state_nxt = orls_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      orls_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      orls_pkg::ST_EXEC: begin
        unique case (sts.cmd)
          orls_pkg::CMD_SAVE: begin
            ctl.mem_we = 1'b1;
            if (sts.tail_slow) begin
              ctl.div_start = 1'b1;
            end else begin
              ctl.tail_adv = 1'b1;
            end
          end
          orls_pkg::CMD_READ:  ctl.mem_re    = 1'b1;
          orls_pkg::CMD_LOOK:  ctl.look_load = 1'b1;
          orls_pkg::CMD_CLEAR: ctl.ptr_clear = 1'b1;
          default: ;
        endcase
      end
      orls_pkg::ST_TDIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          ctl.tail_adv     = 1'b1;
          ctl.adv_from_div = 1'b1;
        end
      end
      orls_pkg::ST_HCHK: begin
        if (sts.ptr_meet) begin
          if (sts.head_slow) begin
            ctl.div_start    = 1'b1;
            ctl.div_sel_head = 1'b1;
          end else begin
            ctl.head_adv = 1'b1;
          end
        end
      end
      orls_pkg::ST_HDIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          ctl.head_adv     = 1'b1;
          ctl.adv_from_div = 1'b1;
        end
      end
      orls_pkg::ST_RESULT: begin
        ctl.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/overwriting_ring_log_store_core.sv */
// Ring log store top level: channels, configuration port, controller and datapath.
// Circular log of 1024 records (port, period, data) that drops the oldest record when
// full. One item is worked at a time: read, lookback and clear pass through the execute
// and result states, and a save also passes through the head check. After the capacity register
// is lowered, a tail that lies beyond the new capacity is brought back into range by
// an 11-step restoring remainder unit, which lengthens that save. The head only
// advances when it equals the freshly advanced tail, which is already in range, so the
// head never waits on the remainder unit. The output register holds a finished result
// while the next item is taken in; the result stage waits only when that register is
// still full. Records never written read back as undefined data; the store needs no
// clearing.
module overwriting_ring_log_store_core (
  input  logic                       clk,
  input  logic                       rst_n,
  orls_in_if.sink                    in_ch,
  orls_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [orls_pkg::CAP_W-1:0] cfg_wdata
);

  orls_pkg::in_item_t  in_item;
  orls_pkg::out_item_t out_item;
  orls_pkg::ctrl_t     ctl;
  orls_pkg::status_t   sts;
  logic                in_ready;
  logic                out_valid;

  // Input payload gathered into one item
  assign in_item.cmd        = in_ch.cmd;
  assign in_item.rec_port   = in_ch.rec_port;
  assign in_item.rec_period = in_ch.rec_period;
  assign in_item.rec_data   = in_ch.rec_data;
  assign in_item.slot       = in_ch.slot;
  assign in_item.lookback   = in_ch.lookback;
  assign in_ch.ready        = in_ready;

  orls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  orls_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Result channel
  assign out_ch.valid      = out_valid;
  assign out_ch.out_port   = out_item.out_port;
  assign out_ch.out_period = out_item.out_period;
  assign out_ch.out_data   = out_item.out_data;
  assign out_ch.found_slot = out_item.found_slot;
  assign out_ch.head_now   = out_item.head_now;
  assign out_ch.tail_now   = out_item.tail_now;

`ifndef ASSERT_OFF
  // An accepted item is worked alone: no new transfer the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is still in work");

  // Loading a result always presents it next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_ch.valid)
    else $error("loaded result not presented");

  // The remainder unit never runs while the input side is open
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.div_start || ctl.div_step) |-> !in_ch.ready)
    else $error("remainder unit active while idle");

  // Memory is written or read, never both in one cycle
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mem_we && ctl.mem_re))
    else $error("memory written and read together");
`endif

endmodule

/* dv/ring_log_checker.sv */
// Transfer monitor, log-store predictor and result comparison for the ring log store.
`timescale 1ns / 1ps

module ring_log_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  orls_in_if                              in_ch,
  orls_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [orls_pkg::CAP_W-1:0]      cfg_wdata,
  output int                              mismatches,
  output int                              awaiting,
  output logic [orls_pkg::SLOTS-1:0]      slot_written
);
  import orls_pkg::*;

  typedef struct packed {
    logic [PORT_W-1:0]   port;
    logic [PERIOD_W-1:0] period;
    logic [DATA_W-1:0]   data;
  } log_rec_t;

  // Shadow copy of the log state
  log_rec_t         rec_mem [SLOTS];
  int unsigned      head_q;
  int unsigned      tail_q;
  logic [CAP_W-1:0] cap_reg;
  out_item_t        pending_results [$];

  // Capacity clamped to 2..SLOTS
  function automatic int unsigned ring_cap();
    if (cap_reg < CAP_MIN) return 2;
    if (cap_reg > CAP_MAX) return SLOTS;
    return int'(cap_reg);
  endfunction

  // Slot n records behind the tail; out-of-range counts answer the head
  function automatic int unsigned lookback_slot(int unsigned n);
    int unsigned cap;
    cap = ring_cap();
    if (n < 1 || n > cap) return head_q;
    if (head_q > tail_q) begin
      // wrapped ring: counts past the tail wrap around the top
      if (n > tail_q) return cap - (n - tail_q);
      return tail_q - n;
    end
    if (n > tail_q) return head_q;
    return tail_q - n;
  endfunction

  // Apply one command to the shadow state and return its result
  function automatic out_item_t advance_log(in_item_t it);
    out_item_t   r;
    int unsigned cap;
    r   = '0;
    cap = ring_cap();
    case (cmd_t'(it.cmd))
      CMD_SAVE: begin
        rec_mem[tail_q].port   = it.rec_port;
        rec_mem[tail_q].period = it.rec_period;
        rec_mem[tail_q].data   = it.rec_data;
        tail_q = (tail_q + 1) % cap;
        // full ring: drop the oldest record
        if (tail_q == head_q) head_q = (head_q + 1) % cap;
      end
      CMD_READ: begin
        r.out_port   = rec_mem[it.slot].port;
        r.out_period = rec_mem[it.slot].period;
        r.out_data   = rec_mem[it.slot].data;
      end
      CMD_LOOK: r.found_slot = PTR_W'(lookback_slot(int'(it.lookback)));
      default: begin
        head_q = 0;
        tail_q = 0;
      end
    endcase
    r.head_now = PTR_W'(head_q);
    r.tail_now = PTR_W'(tail_q);
    return r;
  endfunction

  function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Watch both channels and the config port at each rising edge
  always @(posedge clk) begin
    in_item_t  it;
    out_item_t want;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      head_q  = 0;
      tail_q  = 0;
      cap_reg = CAP_MAX;
      pending_results.delete();
      slot_written <= '0;
      mismatches   <= 0;
      awaiting     <= 0;
    end else begin
      // result transfer: compare with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected", $time);
          bad = 1;
        end else begin
          want = pending_results.pop_front();
          bad += field_check("out_port", 32'(want.out_port), 32'(out_ch.out_port));
          bad += field_check("out_period", 32'(want.out_period), 32'(out_ch.out_period));
          bad += field_check("out_data", want.out_data, out_ch.out_data);
          bad += field_check("found_slot", 32'(want.found_slot), 32'(out_ch.found_slot));
          bad += field_check("head_now", 32'(want.head_now), 32'(out_ch.head_now));
          bad += field_check("tail_now", 32'(want.tail_now), 32'(out_ch.tail_now));
        end
      end
      // input transfer: predict its result
      if (in_ch.valid && in_ch.ready) begin
        it.cmd        = in_ch.cmd;
        it.rec_port   = in_ch.rec_port;
        it.rec_period = in_ch.rec_period;
        it.rec_data   = in_ch.rec_data;
        it.slot       = in_ch.slot;
        it.lookback   = in_ch.lookback;
        if (cmd_t'(it.cmd) == CMD_SAVE) slot_written[tail_q] <= 1'b1;
        pending_results.push_back(advance_log(it));
      end
      if (cfg_we) cap_reg = cfg_wdata;
      mismatches <= mismatches + bad;
      awaiting   <= pending_results.size();
    end
  end

endmodule

/* dv/testbench.sv */
// Top of the ring log store testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module testbench;
  import orls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CAP_W-1:0]  cfg_wdata;
  int                mismatches;
  int                awaiting;
  logic [SLOTS-1:0]  slot_written;
  int                cycles;
  int                cur_cap;
  bit                long_hold_req;
  bit                calm;

  orls_in_if  in_ch ();
  orls_out_if out_ch ();

  overwriting_ring_log_store_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ring_log_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .slot_written (slot_written)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin : rx_side
    int  r;
    int  n;
    bit  held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !held) begin
        held         = 1'b1;
        out_ch.ready = 1'b0;
        repeat (120) @(negedge clk);
      end else if (calm) begin
        out_ch.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready = 1'b1;
        end else begin
          out_ch.ready = 1'b0;
          n = (r < 92) ? $urandom_range(1, 3) :
              (r < 98) ? $urandom_range(4, 12) : $urandom_range(20, 50);
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // Offer one item and wait for its transfer
  task automatic send(cmd_t c, logic [7:0] port, logic [15:0] period, logic [31:0] data,
                      logic [9:0] slot, logic [15:0] look);
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.cmd        = c;
    in_ch.rec_port   = port;
    in_ch.rec_period = period;
    in_ch.rec_data   = data;
    in_ch.slot       = slot;
    in_ch.lookback   = look;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop offering until every result has been taken
  task automatic drain();
    pause(1);
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic set_cap(int v);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = CAP_W'(v);
    cur_cap   = (v < 2) ? 2 : (v > SLOTS) ? SLOTS : v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic idle_gap();
    int r;
    if (calm) return;
    r = $urandom_range(0, 99);
    if (r < 65) return;
    if (r < 90) pause($urandom_range(1, 3));
    else if (r < 97) pause($urandom_range(4, 12));
    else pause($urandom_range(20, 45));
  endtask

  // Random field of width w with extra weight on all-zero and all-one
  function automatic logic [31:0] rand_field(int w);
    logic [31:0] mask;
    int          r;
    mask = (w == 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 1;
    r    = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return mask;
    return $urandom & mask;
  endfunction

  // Only slots already written are read
  function automatic logic [9:0] pick_slot();
    int s;
    for (int k = 0; k < 200; k++) begin
      s = (k % 2 == 0) ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, 15);
      if (slot_written[s]) return 10'(s);
    end
    for (int k = 0; k < SLOTS; k++)
      if (slot_written[k]) return 10'(k);
    return '0;
  endfunction

  function automatic logic [15:0] pick_lookback();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 16'($urandom_range(0, cur_cap + 2));
    if (r < 6) begin
      case ($urandom_range(0, 4))
        0:       return 16'd0;
        1:       return 16'd1;
        2:       return 16'(cur_cap);
        3:       return 16'(cur_cap + 1);
        default: return 16'hFFFF;
      endcase
    end
    if (r < 8) return 16'($urandom);
    return 16'($urandom_range(1, 16));
  endfunction

  task automatic random_item(int save_pct, int read_pct, int look_pct);
    int   r;
    cmd_t c;
    r = $urandom_range(0, 99);
    if (r < save_pct || slot_written == '0) c = CMD_SAVE;
    else if (r < save_pct + read_pct) c = CMD_READ;
    else if (r < save_pct + read_pct + look_pct) c = CMD_LOOK;
    else c = CMD_CLEAR;
    send(c, 8'(rand_field(8)), 16'(rand_field(16)), rand_field(32),
         (c == CMD_READ) ? pick_slot() : 10'($urandom_range(0, SLOTS - 1)),
         pick_lookback());
    idle_gap();
  endtask

  // Stimulus
  initial begin : stim
    int caps [8];
    int lens [8];
    int n;
    caps = '{0, 1, 40, 5, 2047, 3, 300, 0};
    lens = '{10, 10, 40, 10, 15, 10, 10, 10};
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_SAVE;
    in_ch.rec_port   = '0;
    in_ch.rec_period = '0;
    in_ch.rec_data   = '0;
    in_ch.slot       = '0;
    in_ch.lookback   = '0;
    cur_cap          = SLOTS;
    long_hold_req    = 1'b0;
    calm             = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, every command, lookback corner cases
    send(CMD_SAVE, 8'h00, 16'h0000, 32'h0000_0000, 10'h000, 16'h0000);
    send(CMD_SAVE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF);
    idle_gap();
    send(CMD_SAVE, 8'h5A, 16'hA5C3, 32'h1234_5678, 10'h155, 16'h2AAA);
    send(CMD_READ, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 10'd0, 16'h0000);
    send(CMD_READ, 8'h00, 16'h0000, 32'h0000_0000, 10'd1, 16'h0000);
    send(CMD_READ, 8'h00, 16'h0000, 32'h0000_0000, 10'd2, 16'h0000);
    idle_gap();
    // zero count, in range, exactly tail, past tail, capacity, past capacity, max
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd0);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd1);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd3);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd4);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd1024);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd1025);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'hFFFF);
    // clear keeps the records
    send(CMD_CLEAR, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd0);
    send(CMD_READ, 8'h00, 16'h0000, 32'h0, 10'd1, 16'd0);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd1);
    // smallest ring: overwrite the oldest, then lookback on a wrapped ring
    set_cap(2);
    send(CMD_SAVE, 8'h11, 16'h2222, 32'h3333_3333, 10'd0, 16'd0);
    send(CMD_SAVE, 8'h44, 16'h5555, 32'h6666_6666, 10'd0, 16'd0);
    send(CMD_SAVE, 8'h77, 16'h8888, 32'h9999_9999, 10'd0, 16'd0);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd1);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd2);
    send(CMD_LOOK, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd3);
    send(CMD_READ, 8'h00, 16'h0000, 32'h0, 10'd1, 16'd0);
    send(CMD_CLEAR, 8'h00, 16'h0000, 32'h0, 10'd0, 16'd0);

    // Full ring, mostly saves, until the upper half of the store holds records
    set_cap(1024);
    n = 0;
    while (!slot_written[515]) begin
      if (n == 40) long_hold_req = 1'b1;
      if (n == 120) drain();
      calm = (n >= 200 && n < 260);
      random_item(95, 3, 2);
      n++;
    end
    calm = 1'b0;

    // Capacity sweep: saturation at both ends, shrinking under live pointers
    caps[7] = $urandom_range(6, 1023);
    for (int p = 0; p < 8; p++) begin
      set_cap(caps[p]);
      for (int k = 0; k < lens[p]; k++) begin
        calm = (p == 2 && k < 25);
        if (p == 2) random_item(70, 10, 15);
        else random_item(45, 20, 30);
      end
      calm = 1'b0;
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
